// ===== rtl/multi_slot_timer_table_core_macros.svh =====
// assertion macros for the multi-slot timer table
// used by the top level; needs nothing else
`ifndef MULTI_SLOT_TIMER_TABLE_CORE_MACROS_SVH
`define MULTI_SLOT_TIMER_TABLE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MSTT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// next-cycle implication, off during reset
`define MSTT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

// ===== rtl/mstt_pkg.sv =====
// shared types and constants for the multi-slot timer table
// no dependencies
package mstt_pkg;

  // defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF   = 16;
  localparam int PERIOD_BITS_DEF = 32;

  // fixed field widths
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 4;
  localparam int PERIOD_IN_W = 32;
  localparam int KIND_W      = 2;
  localparam int TICK_W      = 64;
  localparam int MAX_SLOTS   = 16;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  // register index as decoded from paddr[2]
  localparam logic CFG_IDX_TIMER_ENABLE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_CANCEL   = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_ACCEPT = 2'd0,
    EV_REJECT = 2'd1,
    EV_EXPIRY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SLOT_W-1:0]      slot;
    logic [PERIOD_IN_W-1:0] period;
    logic                   repeat_req;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [SLOT_W-1:0] event_slot;
    logic              event_repeat;
    logic [TICK_W-1:0] event_tick;
    logic              last;
  } out_item_t;

endpackage

// ===== rtl/mstt_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mstt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/multi_slot_timer_table_core.sv =====
// top level of the multi-slot timer table
// uses mstt_pkg, mstt_ram and the assertion macro header
//
// A register item is accepted and its acknowledge staged, then moved to the
// output register; a cancel likewise. A tick item, when the timer is enabled,
// is accepted and then scans all min(NUM_SLOTS, 16) slots, one slot per cycle
// unless stalled, through the single read port of the period/remaining ram;
// armed slots are read and written back in a two-stage read-modify-write
// pipeline. Ticks with nothing armed still scan the table. An expiry is held
// in a one-entry staging register until the next expiry or the end of the scan
// tells whether it is the last one, so the scan pauses whenever a second expiry
// is found while the output register is still full. The next item is accepted
// once all results of the current one sit in the output register. No clearing
// pass is needed after reset.
`include "multi_slot_timer_table_core_macros.svh"

module multi_slot_timer_table_core #(
  parameter int NUM_SLOTS   = mstt_pkg::NUM_SLOTS_DEF,
  parameter int PERIOD_BITS = mstt_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mstt_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mstt_pkg::out_item_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mstt_pkg::PADDR_W-1:0]     paddr,
  input  logic [mstt_pkg::DATA_W-1:0]      pwdata,
  output logic [mstt_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int DEPTH = (NUM_SLOTS < mstt_pkg::MAX_SLOTS) ? NUM_SLOTS : mstt_pkg::MAX_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PB    = PERIOD_BITS;
  localparam logic [mstt_pkg::SLOT_W:0] SLOT_LIMIT = (mstt_pkg::SLOT_W + 1)'(DEPTH);
  localparam logic [CW-1:0] SCAN_END = CW'(DEPTH);

  // control state
  mstt_pkg::state_t state, state_next;
  logic                          timer_enable;
  logic [mstt_pkg::TICK_W-1:0]   tick_count;
  logic [DEPTH-1:0]              slot_active;
  logic [DEPTH-1:0]              slot_repeat;
  logic [CW-1:0]                 scan_idx;
  logic                          wb_valid;
  logic [AW-1:0]                 wb_idx;
  logic                          pend_valid;
  mstt_pkg::kind_t               pend_kind;
  logic [mstt_pkg::SLOT_W-1:0]   pend_slot;
  logic                          pend_repeat;

  // datapath signals
  logic                          in_fire;
  logic                          out_free;
  logic                          is_tick, is_reg, is_cancel;
  logic                          slot_ok, reg_ok;
  logic [PB-1:0]                 reg_period;
  logic [AW-1:0]                 in_addr;
  logic [2*PB-1:0]               ram_rdata;
  logic [2*PB-1:0]               ram_wdata;
  logic [AW-1:0]                 ram_waddr;
  logic                          ram_we;
  logic                          rd_en;
  logic [PB-1:0]                 rd_period, rd_rem, wb_rem_dec;
  logic                          wb_expire;
  logic                          stall, advance;
  logic                          scan_more;
  logic [AW-1:0]                 scan_addr;
  logic                          push_mid, push_end, push;
  logic                          cfg_we;

  // input decode
  assign in_ready  = (state == mstt_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_tick   = (in_data.op == mstt_pkg::OP_TICK);
  assign is_reg    = (in_data.op == mstt_pkg::OP_REGISTER);
  assign is_cancel = (in_data.op == mstt_pkg::OP_CANCEL);
  assign slot_ok   = ({1'b0, in_data.slot} < SLOT_LIMIT);
  assign in_addr   = in_data.slot[AW-1:0];

  // period fitted to the stored width
  if (PB <= mstt_pkg::PERIOD_IN_W) begin : g_period_trunc
    assign reg_period = in_data.period[PB-1:0];
  end else begin : g_period_ext
    assign reg_period = {{(PB - mstt_pkg::PERIOD_IN_W){1'b0}}, in_data.period};
  end

  assign reg_ok = timer_enable && (reg_period != '0) && slot_ok;

  // scan pipeline: read stage and write-back stage
  assign out_free   = !out_valid || out_ready;
  assign rd_period  = ram_rdata[2*PB-1:PB];
  assign rd_rem     = ram_rdata[PB-1:0];
  assign wb_rem_dec = rd_rem - PB'(1);
  assign wb_expire  = wb_valid && (wb_rem_dec == '0);
  assign stall      = wb_expire && pend_valid && !out_free;
  assign advance    = (state == mstt_pkg::ST_SCAN) && !stall;
  assign scan_more  = (scan_idx < SCAN_END);
  assign scan_addr  = scan_idx[AW-1:0];
  assign rd_en      = advance && scan_more && slot_active[scan_addr];

  // ram write port: registration at accept, or scan write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_idx;
    ram_wdata = {rd_period, wb_expire ? rd_period : wb_rem_dec};
    if (in_fire && is_reg && reg_ok) begin
      ram_we    = 1'b1;
      ram_waddr = in_addr;
      ram_wdata = {reg_period, reg_period};
    end else if (advance && wb_valid) begin
      ram_we    = 1'b1;
    end
  end

  mstt_ram #(
    .WIDTH (2 * PB),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  // staged result moves to the output register
  assign push_mid = advance && wb_expire && pend_valid;
  assign push_end = (state == mstt_pkg::ST_FLUSH) && pend_valid && out_free;
  assign push     = push_mid || push_end;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mstt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_tick && timer_enable) begin
            state_next = mstt_pkg::ST_SCAN;
          end else if (is_reg || is_cancel) begin
            state_next = mstt_pkg::ST_FLUSH;
          end
        end
      end
      mstt_pkg::ST_SCAN: begin
        if (advance && !scan_more) begin
          state_next = mstt_pkg::ST_FLUSH;
        end
      end
      mstt_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = mstt_pkg::ST_IDLE;
        end
      end
      default: state_next = mstt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mstt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tick count and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      slot_active <= '0;
      slot_repeat <= '0;
    end else begin
      if (in_fire && is_tick && timer_enable) begin
        tick_count <= tick_count + mstt_pkg::TICK_W'(1);
      end
      if (in_fire && is_reg && reg_ok) begin
        slot_active[in_addr] <= 1'b1;
        slot_repeat[in_addr] <= in_data.repeat_req;
      end
      if (in_fire && is_cancel && slot_ok) begin
        slot_active[in_addr] <= 1'b0;
      end
      if (advance && wb_expire && !slot_repeat[wb_idx]) begin
        slot_active[wb_idx] <= 1'b0;
      end
    end
  end

  // scan pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      wb_valid <= 1'b0;
    end else if (in_fire) begin
      scan_idx <= '0;
      wb_valid <= 1'b0;
    end else if (advance) begin
      wb_valid <= scan_more && slot_active[scan_addr];
      if (scan_more) begin
        scan_idx <= scan_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wb_idx <= scan_addr;
    end
  end

  // staging register for the newest result
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire && (is_reg || is_cancel)) begin
      pend_valid <= 1'b1;
    end else if (advance && wb_expire) begin
      pend_valid <= 1'b1;
    end else if (push_end) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_slot   <= in_data.slot;
      pend_repeat <= 1'b0;
      if (is_reg) begin
        pend_kind <= reg_ok ? mstt_pkg::EV_ACCEPT : mstt_pkg::EV_REJECT;
      end else begin
        pend_kind <= slot_ok ? mstt_pkg::EV_ACCEPT : mstt_pkg::EV_REJECT;
      end
    end else if (advance && wb_expire) begin
      pend_kind   <= mstt_pkg::EV_EXPIRY;
      pend_slot   <= mstt_pkg::SLOT_W'(wb_idx);
      pend_repeat <= slot_repeat[wb_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.event_kind   <= pend_kind;
      out_data.event_slot   <= pend_slot;
      out_data.event_repeat <= pend_repeat;
      out_data.event_tick   <= (pend_kind == mstt_pkg::EV_EXPIRY) ? tick_count : '0;
      out_data.last         <= push_end;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == mstt_pkg::CFG_IDX_TIMER_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_enable <= 1'b1;
    end else if (cfg_we) begin
      timer_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == mstt_pkg::CFG_IDX_TIMER_ENABLE) ?
                  {{(mstt_pkg::DATA_W - 1){1'b0}}, timer_enable} : '0;

  // checks
  `MSTT_ASSERT_IMP(a_idle_no_pend, clk, rst, state == mstt_pkg::ST_IDLE, !pend_valid)
  `MSTT_ASSERT_IMP(a_wb_slot_armed, clk, rst, wb_valid, slot_active[wb_idx])
  `MSTT_ASSERT_NXT(a_tick_scans, clk, rst, in_fire && is_tick && timer_enable, state == mstt_pkg::ST_SCAN)
  `MSTT_ASSERT_IMP(a_scan_bound, clk, rst, 1'b1, scan_idx <= SCAN_END)
  `MSTT_ASSERT_IMP(a_push_needs_room, clk, rst, push, out_free)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the multi-slot timer table core
// depends on mstt_pkg and multi_slot_timer_table_core; predicts every result item
module tb_top;

  localparam int TABLE_SLOTS = (mstt_pkg::NUM_SLOTS_DEF < mstt_pkg::MAX_SLOTS) ?
                               mstt_pkg::NUM_SLOTS_DEF : mstt_pkg::MAX_SLOTS;
  localparam int SCAN_SETTLE = 40;
  localparam int LONG_HOLD   = 400;
  localparam logic [mstt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [mstt_pkg::PADDR_W-1:0] ENABLE_ADDR =
    {mstt_pkg::CFG_IDX_TIMER_ENABLE, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mstt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mstt_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mstt_pkg::PADDR_W-1:0] paddr = '0;
  logic [mstt_pkg::DATA_W-1:0] pwdata = '0;
  logic [mstt_pkg::DATA_W-1:0] prdata;
  logic pready;

  multi_slot_timer_table_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted timer table
  bit                                 timer_enabled = 1'b1;
  bit                                 slot_armed [TABLE_SLOTS];
  bit                                 slot_repeats [TABLE_SLOTS];
  bit [mstt_pkg::PERIOD_BITS_DEF-1:0] slot_reload [TABLE_SLOTS];
  bit [mstt_pkg::PERIOD_BITS_DEF-1:0] slot_left [TABLE_SLOTS];
  bit [mstt_pkg::TICK_W-1:0]          tick_now = '0;

  mstt_pkg::out_item_t expected_events[$];
  mstt_pkg::in_item_t  pending_items[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned error_count = 0;
  bit idle_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("tb_top: mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // gap lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // expected results of one accepted item
  task automatic apply_timer_item(input mstt_pkg::in_item_t it);
    mstt_pkg::out_item_t ev;
    bit fired [TABLE_SLOTS];
    bit fired_rep [TABLE_SLOTS];
    int fire_total;
    int k;
    bit ok;
    bit [mstt_pkg::PERIOD_BITS_DEF-1:0] per;
    fire_total = 0;
    k = 0;
    per = it.period[mstt_pkg::PERIOD_BITS_DEF-1:0];
    ev = '0;
    case (it.op)
      mstt_pkg::OP_TICK: begin
        if (timer_enabled) begin
          tick_now = tick_now + mstt_pkg::TICK_W'(1);
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            fired[i] = 1'b0;
            fired_rep[i] = slot_repeats[i];
            if (slot_armed[i]) begin
              slot_left[i] = slot_left[i] - mstt_pkg::PERIOD_BITS_DEF'(1);
              if (slot_left[i] == 0) begin
                fired[i] = 1'b1;
                fire_total++;
                if (slot_repeats[i]) slot_left[i] = slot_reload[i];
                else slot_armed[i] = 1'b0;
              end
            end
          end
          // expiries go out lowest slot first
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (fired[i]) begin
              k++;
              ev.event_kind   = mstt_pkg::EV_EXPIRY;
              ev.event_slot   = i[mstt_pkg::SLOT_W-1:0];
              ev.event_repeat = fired_rep[i];
              ev.event_tick   = tick_now;
              ev.last         = (k == fire_total);
              expected_events.push_back(ev);
            end
          end
        end
      end
      mstt_pkg::OP_REGISTER: begin
        ok = timer_enabled && per != 0 && int'(it.slot) < TABLE_SLOTS;
        if (ok) begin
          slot_armed[it.slot]   = 1'b1;
          slot_repeats[it.slot] = it.repeat_req;
          slot_reload[it.slot]  = per;
          slot_left[it.slot]    = per;
        end
        ev.event_kind = ok ? mstt_pkg::EV_ACCEPT : mstt_pkg::EV_REJECT;
        ev.event_slot = it.slot;
        ev.last       = 1'b1;
        expected_events.push_back(ev);
      end
      mstt_pkg::OP_CANCEL: begin
        ok = int'(it.slot) < TABLE_SLOTS;
        if (ok) slot_armed[it.slot] = 1'b0;
        ev.event_kind = ok ? mstt_pkg::EV_ACCEPT : mstt_pkg::EV_REJECT;
        ev.event_slot = it.slot;
        ev.last       = 1'b1;
        expected_events.push_back(ev);
      end
      default: begin
      end
    endcase
  endtask

  // item driver
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_timer_item(in_data);
        items_accepted++;
      end
      if (in_valid && !in_ready) begin
        // hold the offered item
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_off ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    mstt_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          flag_error($sformatf("unexpected item kind %0d slot %0d",
                               out_data.event_kind, out_data.event_slot));
        end else begin
          want = expected_events.pop_front();
          if (out_data.event_kind !== want.event_kind)
            flag_error($sformatf("item %0d kind got %0d want %0d", results_seen,
                                 out_data.event_kind, want.event_kind));
          if (out_data.event_slot !== want.event_slot)
            flag_error($sformatf("item %0d slot got %0d want %0d", results_seen,
                                 out_data.event_slot, want.event_slot));
          if (out_data.event_repeat !== want.event_repeat)
            flag_error($sformatf("item %0d repeat got %0d want %0d", results_seen,
                                 out_data.event_repeat, want.event_repeat));
          if (out_data.event_tick !== want.event_tick)
            flag_error($sformatf("item %0d tick got %0d want %0d", results_seen,
                                 out_data.event_tick, want.event_tick));
          if (out_data.last !== want.last)
            flag_error($sformatf("item %0d last got %0d want %0d", results_seen,
                                 out_data.last, want.last));
        end
      end
      // one long hold-off while the sender keeps offering, to back up the input
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 80 && in_valid) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = idle_off ? 0 : pick_gap();
      end
    end
  end

  task automatic queue_item(input logic [mstt_pkg::OP_W-1:0] op, input int unsigned slot,
                            input logic [mstt_pkg::PERIOD_IN_W-1:0] period, input bit rep);
    mstt_pkg::in_item_t it;
    it.op         = op;
    it.slot       = slot[mstt_pkg::SLOT_W-1:0];
    it.period     = period;
    it.repeat_req = rep;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // mostly short periods so expiries are frequent
  function automatic logic [mstt_pkg::PERIOD_IN_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, 40);
    if (r < 95) return $urandom;
    return '1;
  endfunction

  // random items; unused op codes do not count toward the total
  task automatic queue_random(input int unsigned total);
    int unsigned counted;
    int unsigned r;
    logic [mstt_pkg::OP_W-1:0] op;
    logic [mstt_pkg::PERIOD_IN_W-1:0] per;
    counted = 0;
    while (counted < total) begin
      r = $urandom_range(0, 99);
      per = $urandom;
      if (r < 50) begin
        op = mstt_pkg::OP_TICK;
      end else if (r < 80) begin
        op = mstt_pkg::OP_REGISTER;
        per = pick_period();
      end else if (r < 95) begin
        op = mstt_pkg::OP_CANCEL;
      end else begin
        op = OP_UNUSED;
      end
      queue_item(op, $urandom_range(0, 15), per, 1'($urandom_range(0, 1)));
      if (op != OP_UNUSED) counted++;
    end
  endtask

  // wait until every item is taken and answered, then let a scan finish
  task automatic wait_for_idle();
    while (items_accepted != items_queued || expected_events.size() != 0)
      @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_timer_enable(input logic [mstt_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    timer_enabled = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(mstt_pkg::DATA_W-1){1'b0}}, timer_enabled})
      flag_error($sformatf("timer_enable read back %0h want %0d", prdata, timer_enabled));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_armed[i] = 1'b0;
      slot_repeats[i] = 1'b0;
      slot_reload[i] = '0;
      slot_left[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_timer_enable(32'd1);

    // directed: one-shot, repeat, rejects, restart, unarmed cancel, unused op
    queue_item(mstt_pkg::OP_REGISTER, 0, 32'd1, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 15, '1, 1'b1);
    queue_item(mstt_pkg::OP_REGISTER, 15, '1, 1'b1);
    queue_item(mstt_pkg::OP_REGISTER, 3, 32'd0, 1'b1);
    queue_item(mstt_pkg::OP_REGISTER, 5, 32'd2, 1'b1);
    queue_item(mstt_pkg::OP_REGISTER, 1, 32'd1, 1'b1);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 1, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 7, '1, 1'b1);
    queue_item(OP_UNUSED, 2, 32'd1, 1'b0);
    queue_item(mstt_pkg::OP_REGISTER, 5, 32'd3, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_REGISTER, 3, 32'h8000_0000, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 15, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 3, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_REGISTER, 9, 32'd1, 1'b1);
    wait_for_idle();

    // disabled: registers rejected, ticks silent, cancels still work
    write_timer_enable(32'hFFFF_FFFE);
    queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(mstt_pkg::OP_REGISTER, 9, 32'd4, 1'b0);
    queue_item(mstt_pkg::OP_CANCEL, 9, 32'd0, 1'b0);
    queue_random(30);
    wait_for_idle();

    // full table firing every tick, then cleared
    write_timer_enable(32'd1);
    for (int i = 0; i < TABLE_SLOTS; i++) queue_item(mstt_pkg::OP_REGISTER, i, 32'd1, 1'b1);
    repeat (4) queue_item(mstt_pkg::OP_TICK, 0, 32'd0, 1'b0);
    for (int i = 0; i < TABLE_SLOTS; i++) queue_item(mstt_pkg::OP_CANCEL, i, 32'd0, 1'b0);
    wait_for_idle();

    queue_random(75);
    wait_for_idle();

    // back-to-back stretch with no idling on either side
    idle_off = 1'b1;
    queue_random(60);
    wait_for_idle();
    idle_off = 1'b0;

    write_timer_enable(32'd0);
    queue_random(20);
    wait_for_idle();

    write_timer_enable(32'hFFFF_FFFF);
    queue_random(120);
    wait_for_idle();

    if (expected_events.size() != 0)
      flag_error($sformatf("%0d expected items never arrived", expected_events.size()));
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
